// ===== hdl/iqmb_pkg.sv =====
// ----------------------------------------------------------------------------
// iqmb_pkg
// Shared constants, codes and types of the int8 quantized matrix multiply.
// ----------------------------------------------------------------------------
package iqmb_pkg;

    // Store dimensions.
    localparam int MAX_ROWS  = 16;
    localparam int MAX_INNER = 64;
    localparam int MAX_COLS  = 16;

    localparam int KW       = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int A_DEPTH  = MAX_ROWS * MAX_INNER;
    localparam int B_DEPTH  = MAX_INNER * MAX_COLS;
    localparam int A_ADDR_W = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_ADDR_W = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int BIAS_AW  = CW;

    // Field widths.
    localparam int ACTION_W  = 2;
    localparam int ROW_F_W   = 4;
    localparam int INNER_F_W = 6;
    localparam int COL_F_W   = 4;
    localparam int ELEM_W    = 8;
    localparam int BIAS_W    = 32;
    localparam int ACC_W     = 32;
    localparam int OPND_W    = ELEM_W + 1;
    localparam int S_DATA_W  = 56;
    localparam int S_USER_W  = 2;
    localparam int M_DATA_W  = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int CNT_N_W    = 7;
    localparam int CNT_C_W    = 5;
    localparam int SHIFT_W    = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_A,
        ACT_LOAD_B,
        ACT_LOAD_BIAS,
        ACT_COMPUTE
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INNER_COUNT,
        CFG_COL_COUNT,
        CFG_A_ZP,
        CFG_B_ZP,
        CFG_OUT_ZP,
        CFG_OUT_SHIFT,
        CFG_BIAS_EN
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_RESULT,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic en;
        logic first;
    } mac_ctrl_t;

    typedef struct packed {
        logic [KW-1:0] k_last;
        logic [CW-1:0] c_last;
    } seq_limits_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] a_zp;
        logic signed [ELEM_W-1:0] b_zp;
        logic signed [ELEM_W-1:0] out_zp;
        logic [SHIFT_W-1:0]       out_shift;
    } quant_cfg_t;

endpackage

// ===== hdl/iqmb_ram.sv =====
// ----------------------------------------------------------------------------
// iqmb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module iqmb_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/iqmb_mac.sv =====
// ----------------------------------------------------------------------------
// iqmb_mac
// Shared multiply-accumulate unit with zero-point offset and requantization.
// ----------------------------------------------------------------------------
module iqmb_mac (
    input  logic                          clk,
    input  iqmb_pkg::mac_ctrl_t           ctrl,
    input  logic [iqmb_pkg::ELEM_W-1:0]   a_data,
    input  logic [iqmb_pkg::ELEM_W-1:0]   b_data,
    input  logic [iqmb_pkg::BIAS_W-1:0]   bias_term,
    input  iqmb_pkg::quant_cfg_t          qcfg,
    output logic [iqmb_pkg::ELEM_W-1:0]   q_value
);
    import iqmb_pkg::*;

    logic signed [OPND_W-1:0]   a_off;
    logic signed [OPND_W-1:0]   b_off;
    logic signed [2*OPND_W-1:0] prod;
    logic signed [ACC_W-1:0]    prod_ext;
    logic [ACC_W-1:0]           base;
    logic [ACC_W-1:0]           acc_next;
    logic [ACC_W-1:0]           acc_reg;
    logic signed [ACC_W-1:0]    shifted;

    // Expanding (a - za)(b - zb) gives exactly the zero-point corrected sum,
    // modulo 2^32, so one product per term is enough.
    assign a_off    = $signed({a_data[ELEM_W-1], a_data})
                    - $signed({qcfg.a_zp[ELEM_W-1], qcfg.a_zp});
    assign b_off    = $signed({b_data[ELEM_W-1], b_data})
                    - $signed({qcfg.b_zp[ELEM_W-1], qcfg.b_zp});
    assign prod     = a_off * b_off;
    assign prod_ext = ACC_W'(prod);

    // The first term of a column starts from the bias instead of the old sum.
    assign base     = ctrl.first ? bias_term : acc_reg;
    assign acc_next = base + ACC_W'(prod_ext);

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign shifted = $signed(acc_reg) >>> qcfg.out_shift;
    assign q_value = shifted[ELEM_W-1:0] + ELEM_W'(qcfg.out_zp);

endmodule

// ===== hdl/iqmb_seq.sv =====
// ----------------------------------------------------------------------------
// iqmb_seq
// Sequencer: walks columns and inner terms, drives store reads and the MAC.
// ----------------------------------------------------------------------------
module iqmb_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  iqmb_pkg::action_t               action,
    input  logic [iqmb_pkg::ROW_F_W-1:0]    row_index,
    input  iqmb_pkg::seq_limits_t           limits,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    input  logic [iqmb_pkg::ELEM_W-1:0]     q_value,
    output logic [iqmb_pkg::ELEM_W-1:0]     out_value,
    output logic [iqmb_pkg::COL_F_W-1:0]    out_col,
    output logic                            out_last,
    output logic [iqmb_pkg::A_ADDR_W-1:0]   a_raddr,
    output logic [iqmb_pkg::B_ADDR_W-1:0]   b_raddr,
    output logic [iqmb_pkg::BIAS_AW-1:0]    bias_raddr,
    output iqmb_pkg::mac_ctrl_t             mac_ctrl
);
    import iqmb_pkg::*;

    seq_state_t           state_reg;
    seq_state_t           state_next;
    logic [KW-1:0]        k_reg;
    logic [KW-1:0]        k_next;
    logic [CW-1:0]        c_reg;
    logic [CW-1:0]        c_next;
    logic [ROW_F_W-1:0]   row_reg;
    mac_ctrl_t            ctrl_reg;
    mac_ctrl_t            ctrl_next;
    logic [ELEM_W-1:0]    out_value_reg;
    logic [COL_F_W-1:0]   out_col_reg;
    logic                 out_last_reg;
    logic                 start;
    logic                 k_done;
    logic                 c_done;

    assign start  = s_tvalid && (action == ACT_COMPUTE) && (int'(row_index) < MAX_ROWS);
    assign k_done = (k_reg == limits.k_last);
    assign c_done = (c_reg == limits.c_last);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (k_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = c_done ? ST_IDLE : ST_MAC;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and counter updates.
    always_comb
    begin
        s_tready        = 1'b0;
        m_tvalid        = 1'b0;
        k_next          = '0;
        c_next          = c_reg;
        ctrl_next.en    = 1'b0;
        ctrl_next.first = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                c_next   = '0;
            end
            ST_MAC:
            begin
                if (!k_done)
                begin
                    k_next = k_reg + 1'b1;
                end
                ctrl_next.en    = 1'b1;
                ctrl_next.first = (k_reg == '0);
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready && !c_done)
                begin
                    c_next = c_reg + 1'b1;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            c_reg     <= '0;
            ctrl_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            row_reg <= row_index;
        end
        if (state_reg == ST_RESULT)
        begin
            out_value_reg <= q_value;
            out_col_reg   <= COL_F_W'(c_reg);
            out_last_reg  <= c_done;
        end
    end

    assign a_raddr    = A_ADDR_W'(row_reg) * A_ADDR_W'(MAX_INNER) + A_ADDR_W'(k_reg);
    assign b_raddr    = B_ADDR_W'(k_reg) * B_ADDR_W'(MAX_COLS) + B_ADDR_W'(c_reg);
    assign bias_raddr = BIAS_AW'(c_reg);
    assign mac_ctrl   = ctrl_reg;
    assign out_value  = out_value_reg;
    assign out_col    = out_col_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== hdl/int8_quantized_matmul_bias.sv =====
// ----------------------------------------------------------------------------
// int8_quantized_matmul_bias: int8 matrix multiply with zero points and bias.
// Load items leave s_tready high.
// A compute item holds s_tready low until the result of its final column is
// taken, output stalls included; its columns and inner terms run in turn through
// the one multiply-accumulate unit, with registered store reads.
// Async reset clears the config registers and sequencer state; the stores are not cleared.
// ----------------------------------------------------------------------------
module int8_quantized_matmul_bias (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [iqmb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iqmb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // row_index[3:0], inner_index[9:4], col_index[13:10], element_value[21:14],
    // bias_value[53:22], zero[55:54]
    input  logic [iqmb_pkg::S_DATA_W-1:0]      s_tdata,
    // action[1:0]
    input  logic [iqmb_pkg::S_USER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_value[7:0], out_col[11:8], zero[15:12]
    output logic [iqmb_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tlast
);
    import iqmb_pkg::*;

    action_t               action;
    logic [ROW_F_W-1:0]    row_f;
    logic [INNER_F_W-1:0]  inner_f;
    logic [COL_F_W-1:0]    col_f;
    logic [ELEM_W-1:0]     elem_f;
    logic [BIAS_W-1:0]     bias_f;
    logic                  load_ok;
    logic                  a_we;
    logic                  b_we;
    logic                  bias_we;
    logic [A_ADDR_W-1:0]   a_waddr;
    logic [B_ADDR_W-1:0]   b_waddr;
    logic [A_ADDR_W-1:0]   a_raddr;
    logic [B_ADDR_W-1:0]   b_raddr;
    logic [BIAS_AW-1:0]    bias_raddr;
    logic [ELEM_W-1:0]     a_rdata;
    logic [ELEM_W-1:0]     b_rdata;
    logic [BIAS_W-1:0]     bias_mem [MAX_COLS];
    logic [BIAS_W-1:0]     bias_rd_reg;
    logic [BIAS_W-1:0]     bias_term;
    seq_limits_t           limits_reg;
    quant_cfg_t            qcfg_reg;
    logic                  bias_en_reg;
    mac_ctrl_t             mac_ctrl;
    logic [ELEM_W-1:0]     q_value;
    logic [ELEM_W-1:0]     out_value;
    logic [COL_F_W-1:0]    out_col;
    logic                  out_last;
    logic [CNT_N_W-1:0]    n_val;
    logic [CNT_C_W-1:0]    c_val;

    assign action  = action_t'(s_tuser);
    assign row_f   = s_tdata[ROW_F_W-1:0];
    assign inner_f = s_tdata[ROW_F_W+INNER_F_W-1:ROW_F_W];
    assign col_f   = s_tdata[ROW_F_W+INNER_F_W+COL_F_W-1:ROW_F_W+INNER_F_W];
    assign elem_f  = s_tdata[ROW_F_W+INNER_F_W+COL_F_W+ELEM_W-1:ROW_F_W+INNER_F_W+COL_F_W];
    assign bias_f  = s_tdata[ROW_F_W+INNER_F_W+COL_F_W+ELEM_W+BIAS_W-1:
                             ROW_F_W+INNER_F_W+COL_F_W+ELEM_W];

    assign load_ok = s_tvalid && s_tready;
    assign a_we    = load_ok && (action == ACT_LOAD_A) &&
                     (int'(row_f) < MAX_ROWS) && (int'(inner_f) < MAX_INNER);
    assign b_we    = load_ok && (action == ACT_LOAD_B) &&
                     (int'(inner_f) < MAX_INNER) && (int'(col_f) < MAX_COLS);
    assign bias_we = load_ok && (action == ACT_LOAD_BIAS) && (int'(col_f) < MAX_COLS);
    assign a_waddr = A_ADDR_W'(row_f) * A_ADDR_W'(MAX_INNER) + A_ADDR_W'(inner_f);
    assign b_waddr = B_ADDR_W'(inner_f) * B_ADDR_W'(MAX_COLS) + B_ADDR_W'(col_f);

    assign n_val = cfg_data[CNT_N_W-1:0];
    assign c_val = cfg_data[CNT_C_W-1:0];

    // Counts are stored as the index of the final step; zero acts as one and
    // large values saturate at the store size.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg  <= '0;
            qcfg_reg    <= '0;
            bias_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_INNER_COUNT:
                begin
                    if (n_val == '0)
                    begin
                        limits_reg.k_last <= '0;
                    end
                    else if (int'(n_val) > MAX_INNER)
                    begin
                        limits_reg.k_last <= KW'(MAX_INNER - 1);
                    end
                    else
                    begin
                        limits_reg.k_last <= KW'(n_val - 1'b1);
                    end
                end
                CFG_COL_COUNT:
                begin
                    if (c_val == '0)
                    begin
                        limits_reg.c_last <= '0;
                    end
                    else if (int'(c_val) > MAX_COLS)
                    begin
                        limits_reg.c_last <= CW'(MAX_COLS - 1);
                    end
                    else
                    begin
                        limits_reg.c_last <= CW'(c_val - 1'b1);
                    end
                end
                CFG_A_ZP:      qcfg_reg.a_zp      <= cfg_data[ELEM_W-1:0];
                CFG_B_ZP:      qcfg_reg.b_zp      <= cfg_data[ELEM_W-1:0];
                CFG_OUT_ZP:    qcfg_reg.out_zp    <= cfg_data[ELEM_W-1:0];
                CFG_OUT_SHIFT: qcfg_reg.out_shift <= cfg_data[SHIFT_W-1:0];
                CFG_BIAS_EN:   bias_en_reg        <= cfg_data[0];
                default:
                begin
                    bias_en_reg <= bias_en_reg;
                end
            endcase
        end
    end

    // Bias store; the read is registered and ready the cycle after the column index settles,
    // in time for the first product of that column.
    always_ff @(posedge clk)
    begin
        if (bias_we)
        begin
            bias_mem[BIAS_AW'(col_f)] <= bias_f;
        end
        bias_rd_reg <= bias_mem[bias_raddr];
    end

    assign bias_term = bias_en_reg ? bias_rd_reg : '0;

    iqmb_ram #(
        .DEPTH (A_DEPTH),
        .WIDTH (ELEM_W)
    ) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (elem_f),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    iqmb_ram #(
        .DEPTH (B_DEPTH),
        .WIDTH (ELEM_W)
    ) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (elem_f),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    iqmb_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .action     (action),
        .row_index  (row_f),
        .limits     (limits_reg),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .q_value    (q_value),
        .out_value  (out_value),
        .out_col    (out_col),
        .out_last   (out_last),
        .a_raddr    (a_raddr),
        .b_raddr    (b_raddr),
        .bias_raddr (bias_raddr),
        .mac_ctrl   (mac_ctrl)
    );

    iqmb_mac u_mac (
        .clk       (clk),
        .ctrl      (mac_ctrl),
        .a_data    (a_rdata),
        .b_data    (b_rdata),
        .bias_term (bias_term),
        .qcfg      (qcfg_reg),
        .q_value   (q_value)
    );

    assign m_tdata = {(M_DATA_W - ELEM_W - COL_F_W)'(0), out_col, out_value};
    assign m_tlast = out_last;

endmodule

// ===== hdl/iqmb_checker.sv =====
// ----------------------------------------------------------------------------
// iqmb_checker
// Port-level assertions for the quantized matrix multiply, bound to the top.
// ----------------------------------------------------------------------------
module iqmb_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [iqmb_pkg::S_USER_W-1:0]   s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [iqmb_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                            m_tlast
);
    import iqmb_pkg::*;

    // The block never takes an item while a result is on offer.
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // A compute item makes the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ACT_COMPUTE) |=> !s_tready)
        else $error("block still ready after a compute item");

    // A load item leaves the block ready on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != ACT_COMPUTE) |=> s_tready)
        else $error("block not ready after a load item");

    // Once the final column is taken the block returns to accepting items.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("block not idle after the final column");

endmodule

bind int8_quantized_matmul_bias iqmb_checker u_iqmb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
